/* design/multilevel_feedback_queue_scheduler_core_assert.svh */
// ------------------------------------------------------------------------
// multilevel feedback queue scheduler assertion macros
// concurrent checks that compile away when SYNTHESIS is set
// ------------------------------------------------------------------------
`ifndef MULTILEVEL_FEEDBACK_QUEUE_SCHEDULER_CORE_ASSERT_SVH
`define MULTILEVEL_FEEDBACK_QUEUE_SCHEDULER_CORE_ASSERT_SVH

`ifndef SYNTHESIS

// same-cycle implication
`define MLFQ_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("mlfq assertion failed");

// next-cycle implication
`define MLFQ_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("mlfq assertion failed");

`else

`define MLFQ_ASSERT_NOW(label, clk, rst, ante, cons)
`define MLFQ_ASSERT_NEXT(label, clk, rst, ante, cons)

`endif

`endif

/* design/mlfq_pkg.sv */
// ------------------------------------------------------------------------
// mlfq package
// shared widths, codes, control structs and helpers of the scheduler
// ------------------------------------------------------------------------
package mlfq_pkg;

   localparam int MaxJobs   = 16;
   localparam int MaxLevels = 8;
   localparam int JobW      = 4;
   localparam int LvlW      = 3;
   localparam int CntW      = 5;
   localparam int TimeW     = 32;
   localparam int BurstW    = 16;
   localparam int NlW       = 4;
   localparam int StatW     = 3;
   localparam int CsrIdxW   = 2;
   localparam int CsrDataW  = 16;

   // result status codes
   localparam logic [StatW-1:0] ST_ADDED   = 3'd0;
   localparam logic [StatW-1:0] ST_REJECT  = 3'd1;
   localparam logic [StatW-1:0] ST_SLICE   = 3'd2;
   localparam logic [StatW-1:0] ST_ADVANCE = 3'd3;
   localparam logic [StatW-1:0] ST_NOTHING = 3'd4;

   // register indexes
   localparam logic [CsrIdxW-1:0] CSR_QUANTUM   = 2'd0;
   localparam logic [CsrIdxW-1:0] CSR_THRESHOLD = 2'd1;
   localparam logic [CsrIdxW-1:0] CSR_LEVELS    = 2'd2;

   // request commands
   localparam logic CMD_ADD  = 1'b0;
   localparam logic CMD_STEP = 1'b1;

   typedef struct packed {
      logic [TimeW-1:0]  arrival;
      logic [BurstW-1:0] total;
      logic [BurstW-1:0] remaining;
      logic [TimeW-1:0]  first_start;
   } mlfq_job_type;

   // controller to datapath commands
   typedef struct packed {
      logic capture;
      logic add;
      logic decode;
      logic pop;
      logic run;
      logic admit;
      logic finish;
      logic load;
   } mlfq_cmd_type;

   // datapath to controller status
   typedef struct packed {
      logic is_step;
      logic found;
      logic pend_any;
      logic adv_jump;
      logic admit_ok;
      logic out_free;
   } mlfq_stat_type;

   function automatic logic [TimeW-1:0] sat_add(input logic [TimeW-1:0] a,
                                                input logic [TimeW-1:0] b);
      logic [TimeW:0] s;
      s = {1'b0, a} + {1'b0, b};
      return s[TimeW] ? {TimeW{1'b1}} : s[TimeW-1:0];
   endfunction

endpackage

/* design/mlfq_req_if.sv */
// ------------------------------------------------------------------------
// mlfq request channel
// valid/ready channel carrying add and step requests
// ------------------------------------------------------------------------
interface mlfq_req_if import mlfq_pkg::*; ;
   logic              valid;
   logic              ready;
   logic              cmd;
   logic [JobW-1:0]   job_id;
   logic [TimeW-1:0]  arrival;
   logic [BurstW-1:0] burst;

   modport source (output valid, cmd, job_id, arrival, burst, input ready);
   modport sink   (input valid, cmd, job_id, arrival, burst, output ready);
endinterface

/* design/mlfq_rsp_if.sv */
// ------------------------------------------------------------------------
// mlfq response channel
// valid/ready channel carrying one result per request
// ------------------------------------------------------------------------
interface mlfq_rsp_if import mlfq_pkg::*; ;
   logic             valid;
   logic             ready;
   logic [StatW-1:0] status;
   logic [JobW-1:0]  ran_job;
   logic [LvlW-1:0]  ran_level;
   logic [TimeW-1:0] slice_start;
   logic [TimeW-1:0] time_now;
   logic             finished;
   logic [TimeW-1:0] first_start;
   logic [TimeW-1:0] turnaround;
   logic [TimeW-1:0] waiting;
   logic             all_idle;

   modport source (output valid, status, ran_job, ran_level, slice_start, time_now,
                   finished, first_start, turnaround, waiting, all_idle, input ready);
   modport sink   (input valid, status, ran_job, ran_level, slice_start, time_now,
                   finished, first_start, turnaround, waiting, all_idle, output ready);
endinterface

/* design/mlfq_ctrl.sv */
// ------------------------------------------------------------------------
// mlfq controller
// sequences one request at a time through decode, slice and admission
// ------------------------------------------------------------------------
module mlfq_ctrl import mlfq_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  logic          req_valid,
   output logic          req_ready,
   input  mlfq_stat_type stat,
   output mlfq_cmd_type  cmd
);

   localparam logic [2:0] S_IDLE   = 3'd0;
   localparam logic [2:0] S_DECODE = 3'd1;
   localparam logic [2:0] S_POP    = 3'd2;
   localparam logic [2:0] S_RUN    = 3'd3;
   localparam logic [2:0] S_ADMIT  = 3'd4;
   localparam logic [2:0] S_FINISH = 3'd5;
   localparam logic [2:0] S_DONE   = 3'd6;

   logic [2:0] state_ff, state_in;
   logic       slice_ff, slice_in;

   assign req_ready = (state_ff == S_IDLE);

   // next state and commands
   always_comb begin
      state_in = state_ff;
      slice_in = slice_ff;
      cmd      = '0;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.capture = 1'b1;
               state_in    = S_DECODE;
            end
         end
         S_DECODE: begin
            if (!stat.is_step) begin
               cmd.add  = 1'b1;
               state_in = S_DONE;
            end else begin
               cmd.decode = 1'b1;
               if (stat.found) begin
                  slice_in = 1'b1;
                  state_in = S_POP;
               end else if (stat.pend_any && stat.adv_jump) begin
                  slice_in = 1'b0;
                  state_in = S_ADMIT;
               end else begin
                  state_in = S_DONE;
               end
            end
         end
         S_POP: begin
            cmd.pop  = 1'b1;
            state_in = S_RUN;
         end
         S_RUN: begin
            cmd.run  = 1'b1;
            state_in = S_ADMIT;
         end
         S_ADMIT: begin
            cmd.admit = 1'b1;
            if (!stat.admit_ok) begin
               state_in = slice_ff ? S_FINISH : S_DONE;
            end
         end
         S_FINISH: begin
            cmd.finish = 1'b1;
            state_in   = S_DONE;
         end
         S_DONE: begin
            if (stat.out_free) begin
               cmd.load = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         slice_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         slice_ff <= slice_in;
      end
   end

endmodule

/* design/mlfq_datapath.sv */
// ------------------------------------------------------------------------
// mlfq datapath
// job store, level fifos, sorted pending list, clock and result register
// ------------------------------------------------------------------------
module mlfq_datapath import mlfq_pkg::*; (
   input  logic                clock,
   input  logic                reset,
   input  mlfq_cmd_type        cmd,
   output mlfq_stat_type       stat,
   input  logic                csr_we,
   input  logic [CsrIdxW-1:0]  csr_index,
   input  logic [CsrDataW-1:0] csr_wdata,
   input  logic                in_cmd,
   input  logic [JobW-1:0]     in_job_id,
   input  logic [TimeW-1:0]    in_arrival,
   input  logic [BurstW-1:0]   in_burst,
   input  logic                out_ready,
   output logic                out_valid,
   output logic [StatW-1:0]    out_status,
   output logic [JobW-1:0]     out_ran_job,
   output logic [LvlW-1:0]     out_ran_level,
   output logic [TimeW-1:0]    out_slice_start,
   output logic [TimeW-1:0]    out_time_now,
   output logic                out_finished,
   output logic [TimeW-1:0]    out_first_start,
   output logic [TimeW-1:0]    out_turnaround,
   output logic [TimeW-1:0]    out_waiting,
   output logic                out_all_idle
);

   localparam int FifoAw = LvlW + JobW;

   // configuration
   logic [BurstW-1:0] quantum_ff, thresh_ff;
   logic [NlW-1:0]    levels_ff;

   // captured request
   logic              req_cmd_ff;
   logic [JobW-1:0]   req_id_ff;
   logic [TimeW-1:0]  req_arr_ff;
   logic [BurstW-1:0] req_burst_ff;

   // scheduler state
   logic [TimeW-1:0]  clock_ff, clock_in;
   logic [MaxJobs-1:0] live_ff, live_in, started_ff, started_in;
   logic [CntW-1:0]   cnt_ff  [MaxLevels];
   logic [CntW-1:0]   cnt_in  [MaxLevels];
   logic [JobW-1:0]   head_ff [MaxLevels];
   logic [JobW-1:0]   head_in [MaxLevels];
   logic [CntW-1:0]   pcnt_ff, pcnt_in;
   logic [JobW-1:0]   pid_ff  [MaxJobs];
   logic [JobW-1:0]   pid_in  [MaxJobs];
   logic [TimeW-1:0]  parr_ff [MaxJobs];
   logic [TimeW-1:0]  parr_in [MaxJobs];

   // per-step work registers
   logic [LvlW-1:0]   sel_ff, sel_in;
   logic [JobW-1:0]   ranj_ff, ranj_in;
   logic [BurstW-1:0] rem_ff, rem_in;
   logic [TimeW-1:0]  sstart_ff, sstart_in;
   logic [TimeW-1:0]  first_ff, first_in;
   logic [TimeW-1:0]  tat_ff, tat_in;
   logic              fin_ff, fin_in;
   logic [StatW-1:0]  status_ff, status_in;

   // memories
   logic [JobW-1:0]   fifo_mem [MaxLevels*MaxJobs];
   logic [JobW-1:0]   fifo_rd_ff;
   logic              fifo_we, fifo_re;
   logic [FifoAw-1:0] fifo_waddr, fifo_raddr;
   logic [JobW-1:0]   fifo_wdata;
   mlfq_job_type      job_mem [MaxJobs];
   mlfq_job_type      job_rd_ff;
   logic              job_we, job_re;
   logic [JobW-1:0]   job_waddr, job_raddr;
   mlfq_job_type      job_wdata;

   // result register
   logic              ovalid_ff;

   // clamped configuration
   logic [NlW-1:0]    nl;
   logic [BurstW-1:0] q16;
   logic [LvlW-1:0]   last_lvl;
   assign nl  = (levels_ff < NlW'(2)) ? NlW'(2) :
                (levels_ff > NlW'(MaxLevels)) ? NlW'(MaxLevels) : levels_ff;
   assign q16 = (quantum_ff == '0) ? BurstW'(1) : quantum_ff;
   assign last_lvl = LvlW'(nl - NlW'(1));

   // level selection: first busy round-robin level, then the first-come level
   logic            found;
   logic [LvlW-1:0] sel;
   always_comb begin
      found = 1'b0;
      sel   = '0;
      for (int l = 0; l < MaxLevels; l++) begin
         if (!found && (NlW'(l + 1) < nl) && (cnt_ff[l] != '0)) begin
            found = 1'b1;
            sel   = LvlW'(l);
         end
      end
      if (!found && (cnt_ff[last_lvl] != '0)) begin
         found = 1'b1;
         sel   = last_lvl;
      end
   end

   // idle advance and admission tests
   logic [TimeW:0] adv_sum;
   logic           adv_jump, admit_ok, any_busy;
   assign adv_sum  = {1'b0, clock_ff} + {{(TimeW+1-BurstW){1'b0}}, q16};
   assign adv_jump = ({1'b0, parr_ff[0]} <= adv_sum);
   assign admit_ok = (pcnt_ff != '0) && (parr_ff[0] <= clock_ff);
   always_comb begin
      any_busy = 1'b0;
      for (int l = 0; l < MaxLevels; l++) begin
         any_busy = any_busy | (cnt_ff[l] != '0);
      end
   end

   assign stat.is_step  = (req_cmd_ff == CMD_STEP);
   assign stat.found    = found;
   assign stat.pend_any = (pcnt_ff != '0);
   assign stat.adv_jump = adv_jump;
   assign stat.admit_ok = admit_ok;
   assign stat.out_free = !ovalid_ff || out_ready;

   // sorted insert position of the captured request
   logic [CntW-1:0] ins_pos;
   always_comb begin
      ins_pos = '0;
      for (int k = 0; k < MaxJobs; k++) begin
         if ((CntW'(k) < pcnt_ff) && (parr_ff[k] <= req_arr_ff)) begin
            ins_pos = ins_pos + CntW'(1);
         end
      end
   end

   // slice arithmetic
   logic              not_last, take_q;
   logic [BurstW-1:0] run_len, rem_new;
   logic [LvlW-1:0]   push_lvl;
   assign not_last = ({1'b0, sel_ff} + NlW'(1)) < nl;
   assign take_q   = not_last && (job_rd_ff.remaining > q16);
   assign run_len  = take_q ? q16 : job_rd_ff.remaining;
   assign rem_new  = take_q ? (job_rd_ff.remaining - q16) : '0;
   assign push_lvl = ((job_rd_ff.total - rem_ff) >= thresh_ff) ? (sel_ff + LvlW'(1)) : sel_ff;

   // next state of scheduler
   always_comb begin
      clock_in   = clock_ff;
      live_in    = live_ff;
      started_in = started_ff;
      cnt_in     = cnt_ff;
      head_in    = head_ff;
      pcnt_in    = pcnt_ff;
      pid_in     = pid_ff;
      parr_in    = parr_ff;
      sel_in     = sel_ff;
      ranj_in    = ranj_ff;
      rem_in     = rem_ff;
      sstart_in  = sstart_ff;
      first_in   = first_ff;
      tat_in     = tat_ff;
      fin_in     = fin_ff;
      status_in  = status_ff;
      fifo_we    = 1'b0;
      fifo_waddr = '0;
      fifo_wdata = '0;
      fifo_re    = 1'b0;
      fifo_raddr = '0;
      job_we     = 1'b0;
      job_waddr  = '0;
      job_wdata  = '0;
      job_re     = 1'b0;
      job_raddr  = '0;

      // add: a live id is rejected; ready now goes to level 0, otherwise into the sorted list
      if (cmd.add) begin
         fin_in = 1'b0;
         if (live_ff[req_id_ff]) begin
            status_in = ST_REJECT;
         end else begin
            status_in            = ST_ADDED;
            live_in[req_id_ff]    = 1'b1;
            started_in[req_id_ff] = 1'b0;
            job_we               = 1'b1;
            job_waddr            = req_id_ff;
            job_wdata            = '{arrival: req_arr_ff, total: req_burst_ff,
                                     remaining: req_burst_ff, first_start: '0};
            if (req_arr_ff <= clock_ff) begin
               fifo_we    = 1'b1;
               fifo_waddr = {LvlW'(0), head_ff[0] + cnt_ff[0][JobW-1:0]};
               fifo_wdata = req_id_ff;
               cnt_in[0]  = cnt_ff[0] + CntW'(1);
            end else begin
               for (int k = 1; k < MaxJobs; k++) begin
                  if (CntW'(k) > ins_pos) begin
                     pid_in[k]  = pid_ff[k-1];
                     parr_in[k] = parr_ff[k-1];
                  end
               end
               for (int k = 0; k < MaxJobs; k++) begin
                  if (CntW'(k) == ins_pos) begin
                     pid_in[k]  = req_id_ff;
                     parr_in[k] = req_arr_ff;
                  end
               end
               pcnt_in = pcnt_ff + CntW'(1);
            end
         end
      end

      // step decode: read fifo head, idle advance, or nothing
      if (cmd.decode) begin
         fin_in = 1'b0;
         if (found) begin
            status_in  = ST_SLICE;
            sel_in     = sel;
            fifo_re    = 1'b1;
            fifo_raddr = {sel, head_ff[sel]};
         end else if (pcnt_ff != '0) begin
            status_in = ST_ADVANCE;
            if (adv_jump) begin
               clock_in = parr_ff[0];
            end else begin
               clock_in = adv_sum[TimeW] ? {TimeW{1'b1}} : adv_sum[TimeW-1:0];
            end
         end else begin
            status_in = ST_NOTHING;
         end
      end

      // pop the head and fetch its job entry
      if (cmd.pop) begin
         ranj_in         = fifo_rd_ff;
         job_re          = 1'b1;
         job_raddr       = fifo_rd_ff;
         head_in[sel_ff] = head_ff[sel_ff] + JobW'(1);
         cnt_in[sel_ff]  = cnt_ff[sel_ff] - CntW'(1);
      end

      // run the slice
      if (cmd.run) begin
         sstart_in = clock_ff;
         rem_in    = rem_new;
         clock_in  = sat_add(clock_ff, {{(TimeW-BurstW){1'b0}}, run_len});
         first_in  = started_ff[ranj_ff] ? job_rd_ff.first_start : clock_ff;
         started_in[ranj_ff] = 1'b1;
         job_we    = 1'b1;
         job_waddr = ranj_ff;
         job_wdata = '{arrival: job_rd_ff.arrival, total: job_rd_ff.total,
                       remaining: rem_new, first_start: first_in};
      end

      // admit one arrived job per cycle into level 0
      if (cmd.admit && admit_ok) begin
         for (int k = 0; k < MaxJobs - 1; k++) begin
            pid_in[k]  = pid_ff[k+1];
            parr_in[k] = parr_ff[k+1];
         end
         pcnt_in    = pcnt_ff - CntW'(1);
         fifo_we    = 1'b1;
         fifo_waddr = {LvlW'(0), head_ff[0] + cnt_ff[0][JobW-1:0]};
         fifo_wdata = pid_ff[0];
         cnt_in[0]  = cnt_ff[0] + CntW'(1);
      end

      // retire, demote or requeue the job that ran
      if (cmd.finish) begin
         if (rem_ff == '0) begin
            fin_in           = 1'b1;
            live_in[ranj_ff] = 1'b0;
            tat_in           = clock_ff - job_rd_ff.arrival;
         end else begin
            fifo_we          = 1'b1;
            fifo_waddr       = {push_lvl, head_ff[push_lvl] + cnt_ff[push_lvl][JobW-1:0]};
            fifo_wdata       = ranj_ff;
            cnt_in[push_lvl] = cnt_ff[push_lvl] + CntW'(1);
         end
      end
   end

   // configuration and control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         quantum_ff <= BurstW'(2);
         thresh_ff  <= BurstW'(2);
         levels_ff  <= NlW'(3);
         clock_ff   <= '0;
         live_ff    <= '0;
         started_ff <= '0;
         pcnt_ff    <= '0;
         ovalid_ff  <= 1'b0;
         for (int l = 0; l < MaxLevels; l++) begin
            cnt_ff[l]  <= '0;
            head_ff[l] <= '0;
         end
      end else begin
         if (csr_we) begin
            unique case (csr_index)
               CSR_QUANTUM:   quantum_ff <= csr_wdata;
               CSR_THRESHOLD: thresh_ff  <= csr_wdata;
               CSR_LEVELS:    levels_ff  <= csr_wdata[NlW-1:0];
               default:       ;
            endcase
         end
         clock_ff   <= clock_in;
         live_ff    <= live_in;
         started_ff <= started_in;
         pcnt_ff    <= pcnt_in;
         cnt_ff     <= cnt_in;
         head_ff    <= head_in;
         if (cmd.load) begin
            ovalid_ff <= 1'b1;
         end else if (out_ready) begin
            ovalid_ff <= 1'b0;
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         req_cmd_ff   <= in_cmd;
         req_id_ff    <= in_job_id;
         req_arr_ff   <= in_arrival;
         req_burst_ff <= in_burst;
      end
      pid_ff    <= pid_in;
      parr_ff   <= parr_in;
      sel_ff    <= sel_in;
      ranj_ff   <= ranj_in;
      rem_ff    <= rem_in;
      sstart_ff <= sstart_in;
      first_ff  <= first_in;
      tat_ff    <= tat_in;
      fin_ff    <= fin_in;
      status_ff <= status_in;
   end

   // level fifo memory
   always_ff @(posedge clock) begin
      if (fifo_we) begin
         fifo_mem[fifo_waddr] <= fifo_wdata;
      end
      if (fifo_re) begin
         fifo_rd_ff <= fifo_mem[fifo_raddr];
      end
   end

   // job memory
   always_ff @(posedge clock) begin
      if (job_we) begin
         job_mem[job_waddr] <= job_wdata;
      end
      if (job_re) begin
         job_rd_ff <= job_mem[job_raddr];
      end
   end

   // result register
   logic is_slice;
   assign is_slice = (status_ff == ST_SLICE);
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         out_status      <= status_ff;
         out_ran_job     <= is_slice ? ranj_ff : '0;
         out_ran_level   <= is_slice ? sel_ff : '0;
         out_slice_start <= is_slice ? sstart_ff : '0;
         out_time_now    <= clock_ff;
         out_finished    <= fin_ff;
         out_first_start <= fin_ff ? first_ff : '0;
         out_turnaround  <= fin_ff ? tat_ff : '0;
         out_waiting     <= (fin_ff && (tat_ff >= {{(TimeW-BurstW){1'b0}}, job_rd_ff.total}))
                            ? (tat_ff - {{(TimeW-BurstW){1'b0}}, job_rd_ff.total}) : '0;
         out_all_idle    <= (pcnt_ff == '0) && !any_busy;
      end
   end

   assign out_valid = ovalid_ff;

endmodule

/* design/multilevel_feedback_queue_scheduler_core.sv */
// ------------------------------------------------------------------------
// multilevel feedback queue scheduler core
// top level: controller, datapath and channel hookup
// ------------------------------------------------------------------------
// The core handles one request at a time and keeps req_ch.ready low until
// the result is in the output register. An add passes through decode and
// done. A step that runs a slice passes through decode, pop, run, admit,
// finish and done, staying in admit while pending jobs are admitted into
// level 0; an idle clock advance that jumps to the next arrival passes
// through decode, admit and done, and a one-quantum advance or a step
// with nothing to do through decode and done. The sequence is set by the
// level fifo and job memories, each read with a registered output, and by
// admitting one arrival per cycle from the sorted pending list. Done waits
// for a free output register. A finished result waits in the output
// register while the next request is accepted.
`include "multilevel_feedback_queue_scheduler_core_assert.svh"

module multilevel_feedback_queue_scheduler_core import mlfq_pkg::*; (
   input  logic                clock,
   input  logic                reset,
   mlfq_req_if.sink            req_ch,
   mlfq_rsp_if.source          rsp_ch,
   input  logic                csr_we,
   input  logic [CsrIdxW-1:0]  csr_index,
   input  logic [CsrDataW-1:0] csr_wdata
);

   mlfq_cmd_type  ctrl_cmd;
   mlfq_stat_type dp_stat;

   // sequencer
   mlfq_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_ch.valid),
      .req_ready (req_ch.ready),
      .stat      (dp_stat),
      .cmd       (ctrl_cmd)
   );

   // scheduler state and arithmetic
   mlfq_datapath u_datapath (
      .clock           (clock),
      .reset           (reset),
      .cmd             (ctrl_cmd),
      .stat            (dp_stat),
      .csr_we          (csr_we),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata),
      .in_cmd          (req_ch.cmd),
      .in_job_id       (req_ch.job_id),
      .in_arrival      (req_ch.arrival),
      .in_burst        (req_ch.burst),
      .out_ready       (rsp_ch.ready),
      .out_valid       (rsp_ch.valid),
      .out_status      (rsp_ch.status),
      .out_ran_job     (rsp_ch.ran_job),
      .out_ran_level   (rsp_ch.ran_level),
      .out_slice_start (rsp_ch.slice_start),
      .out_time_now    (rsp_ch.time_now),
      .out_finished    (rsp_ch.finished),
      .out_first_start (rsp_ch.first_start),
      .out_turnaround  (rsp_ch.turnaround),
      .out_waiting     (rsp_ch.waiting),
      .out_all_idle    (rsp_ch.all_idle)
   );

   // checks
   `MLFQ_ASSERT_NEXT(a_one_in_flight, clock, reset, req_ch.valid && req_ch.ready, !req_ch.ready)
   `MLFQ_ASSERT_NOW(a_load_when_free, clock, reset, ctrl_cmd.load, dp_stat.out_free)
   `MLFQ_ASSERT_NOW(a_cmd_onehot, clock, reset, 1'b1, $onehot0(ctrl_cmd))

endmodule

/* verif/tb_multilevel_feedback_queue_scheduler_core.sv */
// ------------------------------------------------------------------------
// multilevel feedback queue scheduler testbench
// drives add and step requests with random gaps and stalls, predicts every
// response with a behavioral scheduler model and compares field by field
// ------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_multilevel_feedback_queue_scheduler_core;
   import mlfq_pkg::*;

   typedef struct {
      logic [StatW-1:0] status;
      logic [JobW-1:0]  ran_job;
      logic [LvlW-1:0]  ran_level;
      logic [TimeW-1:0] slice_start;
      logic [TimeW-1:0] time_now;
      logic             finished;
      logic [TimeW-1:0] first_start;
      logic [TimeW-1:0] turnaround;
      logic [TimeW-1:0] waiting;
      logic             all_idle;
      logic             typed;
      logic [StatW-1:0] typed_status;
      logic [TimeW-1:0] typed_time;
   } sched_result_type;

   typedef struct {
      logic              cmd;
      logic [JobW-1:0]   id;
      logic [TimeW-1:0]  arrival;
      logic [BurstW-1:0] burst;
      logic              typed;
      logic [StatW-1:0]  status;
      logic [TimeW-1:0]  time_now;
   } stim_row_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic                csr_we    = 1'b0;
   logic [CsrIdxW-1:0]  csr_index = CSR_QUANTUM;
   logic [CsrDataW-1:0] csr_wdata = '0;

   mlfq_req_if req_ch ();
   mlfq_rsp_if rsp_ch ();

   multilevel_feedback_queue_scheduler_core dut (
      .clock     (clock),
      .reset     (reset),
      .req_ch    (req_ch),
      .rsp_ch    (rsp_ch),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always #6 clock = ~clock;

   // scheduler shadow state
   logic [TimeW-1:0]  sched_quantum  = 2;
   logic [TimeW-1:0]  sched_thresh   = 2;
   logic [NlW-1:0]    sched_levels   = 3;
   logic [TimeW-1:0]  sched_clock    = '0;
   logic              job_live    [MaxJobs];
   logic [BurstW-1:0] job_left    [MaxJobs];
   logic [BurstW-1:0] job_burst   [MaxJobs];
   logic [TimeW-1:0]  job_arrive  [MaxJobs];
   logic              job_ran     [MaxJobs];
   logic [TimeW-1:0]  job_first   [MaxJobs];
   logic [JobW-1:0]   level_queue [MaxLevels][$];
   logic [JobW-1:0]   arrivals_pending [$];

   sched_result_type expected_results [$];
   int  mismatches = 0;

   // request-side side band for typed directed rows
   logic             row_typed  = 1'b0;
   logic [StatW-1:0] row_status = '0;
   logic [TimeW-1:0] row_time   = '0;

   int  responses_seen = 0;

   function automatic logic [TimeW-1:0] time_sum(logic [TimeW-1:0] a, logic [TimeW-1:0] b);
      logic [TimeW:0] s;
      s = {1'b0, a} + {1'b0, b};
      return s[TimeW] ? {TimeW{1'b1}} : s[TimeW-1:0];
   endfunction

   // move arrived jobs from the pending list into level 0
   function automatic void admit_arrived();
      logic [JobW-1:0] id;
      while (arrivals_pending.size() > 0 && job_arrive[arrivals_pending[0]] <= sched_clock
             && level_queue[0].size() < MaxJobs) begin
         id = arrivals_pending.pop_front();
         level_queue[0] = {level_queue[0], id};
      end
   endfunction

   function automatic sched_result_type schedule_request(logic cmd, logic [JobW-1:0] id,
                                                        logic [TimeW-1:0] arr,
                                                        logic [BurstW-1:0] burst);
      sched_result_type r;
      int nl, lvl, pos;
      logic [TimeW-1:0] q, run, nxt;
      logic [BurstW-1:0] rem;
      logic [JobW-1:0] j;
      bit found, ok;
      r = '{default: '0};
      nl = sched_levels < 2 ? 2 : (sched_levels > MaxLevels ? MaxLevels : sched_levels);
      q  = sched_quantum == 0 ? 1 : sched_quantum;
      found = 1'b0;
      ok = 1'b0;
      lvl = 0;
      if (cmd == CMD_ADD) begin
         r.status = ST_REJECT;
         if (!job_live[id]) begin
            job_arrive[id] = arr;
            job_burst[id]  = burst;
            job_left[id]   = burst;
            job_ran[id]    = 1'b0;
            job_first[id]  = '0;
            if (arr <= sched_clock) begin
               ok = level_queue[0].size() < MaxJobs;
               if (ok) level_queue[0] = {level_queue[0], id};
            end else begin
               ok = arrivals_pending.size() < MaxJobs;
               if (ok) begin
                  pos = 0;
                  while (pos < arrivals_pending.size()
                         && job_arrive[arrivals_pending[pos]] <= arr)
                     pos++;
                  arrivals_pending.insert(pos, id);
               end
            end
            if (ok) begin
               job_live[id] = 1'b1;
               r.status = ST_ADDED;
            end
         end
      end else begin
         for (int l = 0; l < nl - 1; l++)
            if (!found && level_queue[l].size() != 0) begin
               found = 1'b1;
               lvl = l;
            end
         if (!found && level_queue[nl-1].size() != 0) begin
            found = 1'b1;
            lvl = nl - 1;
         end
         if (found) begin
            j = level_queue[lvl].pop_front();
            r.slice_start = sched_clock;
            rem = job_left[j];
            if (lvl + 1 < nl && {16'b0, rem} > q) begin
               run = q;
               rem = rem - q[BurstW-1:0];
            end else begin
               run = {16'b0, rem};
               rem = '0;
            end
            job_left[j] = rem;
            if (!job_ran[j]) begin
               job_ran[j] = 1'b1;
               job_first[j] = r.slice_start;
            end
            sched_clock = time_sum(r.slice_start, run);
            admit_arrived();
            if (rem == 0) begin
               r.finished = 1'b1;
               job_live[j] = 1'b0;
               r.first_start = job_first[j];
               r.turnaround = sched_clock - job_arrive[j];
               r.waiting = r.turnaround >= {16'b0, job_burst[j]}
                           ? r.turnaround - {16'b0, job_burst[j]} : '0;
            end else if ({16'b0, job_burst[j] - rem} >= sched_thresh) begin
               level_queue[lvl+1] = {level_queue[lvl+1], j};
            end else begin
               level_queue[lvl] = {level_queue[lvl], j};
            end
            r.status = ST_SLICE;
            r.ran_job = j;
            r.ran_level = LvlW'(lvl);
         end else if (arrivals_pending.size() != 0) begin
            nxt = job_arrive[arrivals_pending[0]];
            if ({1'b0, nxt} > {1'b0, sched_clock} + {1'b0, q}) begin
               sched_clock = time_sum(sched_clock, q);
            end else begin
               sched_clock = nxt;
               admit_arrived();
            end
            r.status = ST_ADVANCE;
         end else begin
            r.status = ST_NOTHING;
         end
      end
      r.time_now = sched_clock;
      r.all_idle = arrivals_pending.size() == 0;
      for (int l = 0; l < MaxLevels; l++)
         if (level_queue[l].size() != 0) r.all_idle = 1'b0;
      return r;
   endfunction

   task automatic check_field(string name, logic [TimeW-1:0] exp_v, logic [TimeW-1:0] act_v);
      if (exp_v !== act_v) begin
         $error("%s mismatch: expected %0h, got %0h", name, exp_v, act_v);
         mismatches++;
      end
   endtask

   // predict on accepted requests, compare on accepted responses
   always @(posedge clock) begin
      sched_result_type e;
      if (!reset) begin
         if (req_ch.valid && req_ch.ready) begin
            e = schedule_request(req_ch.cmd, req_ch.job_id, req_ch.arrival,
                                 req_ch.burst);
            e.typed = row_typed;
            e.typed_status = row_status;
            e.typed_time = row_time;
            expected_results = {expected_results, e};
         end
         if (rsp_ch.valid && rsp_ch.ready) begin
            responses_seen++;
            if (expected_results.size() == 0) begin
               $error("unexpected response with status %0d", rsp_ch.status);
               mismatches++;
            end else begin
               e = expected_results.pop_front();
               if (e.typed) begin
                  check_field("status (directed)", e.typed_status, rsp_ch.status);
                  check_field("time_now (directed)", e.typed_time, rsp_ch.time_now);
               end
               check_field("status", e.status, rsp_ch.status);
               check_field("ran_job", e.ran_job, rsp_ch.ran_job);
               check_field("ran_level", e.ran_level, rsp_ch.ran_level);
               check_field("slice_start", e.slice_start, rsp_ch.slice_start);
               check_field("time_now", e.time_now, rsp_ch.time_now);
               check_field("finished", e.finished, rsp_ch.finished);
               check_field("first_start", e.first_start, rsp_ch.first_start);
               check_field("turnaround", e.turnaround, rsp_ch.turnaround);
               check_field("waiting", e.waiting, rsp_ch.waiting);
               check_field("all_idle", e.all_idle, rsp_ch.all_idle);
            end
         end
      end
   end

   // response side: random stalls and one long hold-off
   initial begin
      int stall;
      bit held;
      held = 1'b0;
      rsp_ch.ready = 1'b0;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         stall = $urandom_range(0, 7);
         if ($urandom_range(0, 3) == 0) stall = 0;
         if (!held && responses_seen >= 150) begin
            held = 1'b1;
            stall = 400;
         end
         if (stall > 0) begin
            rsp_ch.ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_ch.ready <= 1'b1;
         @(posedge clock);
         while (!rsp_ch.valid) @(posedge clock);
      end
   end

   task automatic send_request(logic cmd, logic [JobW-1:0] id, logic [TimeW-1:0] arr,
                               logic [BurstW-1:0] burst, logic typed = 1'b0,
                               logic [StatW-1:0] st = '0, logic [TimeW-1:0] tn = '0);
      int gap;
      gap = $urandom_range(0, 7);
      if ($urandom_range(0, 3) == 0) gap = 0;
      if (gap > 0) begin
         req_ch.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_ch.valid   <= 1'b1;
      req_ch.cmd     <= cmd;
      req_ch.job_id  <= id;
      req_ch.arrival <= arr;
      req_ch.burst   <= burst;
      row_typed      <= typed;
      row_status     <= st;
      row_time       <= tn;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
   endtask

   // register write once the block has drained
   task automatic write_csr(logic [CsrIdxW-1:0] idx, logic [CsrDataW-1:0] val);
      req_ch.valid <= 1'b0;
      @(posedge clock);
      while (expected_results.size() != 0) @(posedge clock);
      repeat (30) @(posedge clock);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      case (idx)
         CSR_QUANTUM:   sched_quantum = {16'b0, val};
         CSR_THRESHOLD: sched_thresh  = {16'b0, val};
         default:       sched_levels  = val[NlW-1:0];
      endcase
      @(posedge clock);
      csr_we <= 1'b0;
   endtask

   // random request; arrivals near the end of time only when saturation is the goal
   task automatic random_request(bit reach_max);
      logic [TimeW-1:0] arr;
      logic [BurstW-1:0] burst;
      int pick;
      if ($urandom_range(0, 99) < 55) begin
         send_request(CMD_STEP, JobW'($urandom_range(0, 15)), $urandom, BurstW'($urandom));
      end else begin
         pick = $urandom_range(0, 99);
         if (pick < 55)      arr = time_sum(sched_clock, $urandom_range(0, 20));
         else if (pick < 85) arr = sched_clock - $urandom_range(0, 5);
         else if (pick < 88 || reach_max) arr = reach_max ? 32'hFFFF_FFFF - $urandom_range(0, 40)
                                                          : $urandom;
         else arr = sched_clock;
         pick = $urandom_range(0, 99);
         if (pick < 85)      burst = BurstW'($urandom_range(0, 8));
         else if (pick < 97) burst = BurstW'($urandom_range(0, 300));
         else                burst = BurstW'($urandom);
         send_request(CMD_ADD, JobW'($urandom_range(0, 15)), arr, burst);
      end
   endtask

   stim_row_type directed_rows [$] = '{
      '{CMD_STEP, 4'd0,  32'd0,           16'd0,      1'b1, ST_NOTHING, 32'd0},
      '{CMD_ADD,  4'd0,  32'd0,           16'd5,      1'b1, ST_ADDED,   32'd0},
      '{CMD_ADD,  4'd0,  32'd3,           16'd1,      1'b1, ST_REJECT,  32'd0},
      '{CMD_ADD,  4'd15, 32'd10,          16'd0,      1'b1, ST_ADDED,   32'd0},
      '{CMD_ADD,  4'd1,  32'd0,           16'd0,      1'b1, ST_ADDED,   32'd0},
      '{CMD_ADD,  4'd2,  32'hFFFF_FFFF,   16'hFFFF,   1'b1, ST_ADDED,   32'd0},
      '{CMD_ADD,  4'd3,  32'd10,          16'd3,      1'b0, ST_ADDED,   32'd0},
      '{CMD_ADD,  4'd4,  32'd0,           16'hFFFF,   1'b0, ST_ADDED,   32'd0},
      '{CMD_STEP, 4'd0,  32'd0,           16'd0,      1'b1, ST_SLICE,   32'd2},
      '{CMD_STEP, 4'd0,  32'd0,           16'd0,      1'b0, ST_SLICE,   32'd0},
      '{CMD_STEP, 4'd0,  32'd0,           16'd0,      1'b0, ST_SLICE,   32'd0},
      '{CMD_STEP, 4'd0,  32'd0,           16'd0,      1'b0, ST_SLICE,   32'd0},
      '{CMD_STEP, 4'd0,  32'd0,           16'd0,      1'b0, ST_SLICE,   32'd0},
      '{CMD_STEP, 4'd0,  32'd0,           16'd0,      1'b0, ST_SLICE,   32'd0},
      '{CMD_STEP, 4'd0,  32'd0,           16'd0,      1'b0, ST_SLICE,   32'd0},
      '{CMD_STEP, 4'd0,  32'd0,           16'd0,      1'b0, ST_SLICE,   32'd0},
      '{CMD_STEP, 4'd0,  32'd0,           16'd0,      1'b0, ST_SLICE,   32'd0},
      '{CMD_STEP, 4'd0,  32'd0,           16'd0,      1'b0, ST_SLICE,   32'd0},
      '{CMD_STEP, 4'd0,  32'd0,           16'd0,      1'b0, ST_SLICE,   32'd0},
      '{CMD_STEP, 4'd0,  32'd0,           16'd0,      1'b0, ST_SLICE,   32'd0}
   };

   // stimulus: directed table, then random phases over register settings
   initial begin
      for (int k = 0; k < MaxJobs; k++) begin
         job_live[k] = 1'b0;
         job_ran[k]  = 1'b0;
      end
      req_ch.valid = 1'b0;
      req_ch.cmd = CMD_ADD;
      req_ch.job_id = '0;
      req_ch.arrival = '0;
      req_ch.burst = '0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (directed_rows[k])
         send_request(directed_rows[k].cmd, directed_rows[k].id, directed_rows[k].arrival,
                      directed_rows[k].burst, directed_rows[k].typed,
                      directed_rows[k].status, directed_rows[k].time_now);
      repeat (100) random_request(1'b0);

      // single-quantum slices, demote on every slice, two levels
      write_csr(CSR_QUANTUM, 16'd1);
      write_csr(CSR_THRESHOLD, 16'd0);
      write_csr(CSR_LEVELS, 16'd2);
      repeat (80) random_request(1'b0);

      // all eight levels with fast demotion to fill deep levels
      write_csr(CSR_LEVELS, 16'd8);
      write_csr(CSR_THRESHOLD, 16'd1);
      repeat (90) random_request(1'b0);

      // fewer levels strands deep jobs; zero quantum and level count zero
      write_csr(CSR_LEVELS, 16'd0);
      write_csr(CSR_QUANTUM, 16'd0);
      repeat (80) random_request(1'b0);

      // level count above the maximum, widest quantum and threshold
      write_csr(CSR_LEVELS, 16'hF);
      write_csr(CSR_QUANTUM, 16'hFFFF);
      write_csr(CSR_THRESHOLD, 16'hFFFF);
      repeat (80) random_request(1'b0);

      // middle settings, then arrivals near the end of time to saturate the clock
      write_csr(CSR_QUANTUM, 16'd3);
      write_csr(CSR_THRESHOLD, 16'd4);
      write_csr(CSR_LEVELS, 16'd4);
      repeat (90) random_request(1'b0);
      write_csr(CSR_QUANTUM, 16'hFFFF);
      repeat (80) random_request(1'b1);

      req_ch.valid <= 1'b0;
      @(posedge clock);
      while (expected_results.size() != 0) @(posedge clock);
      repeat (40) @(posedge clock);
      if (mismatches == 0 && expected_results.size() == 0)
         $display("[ OK ] regression clean");
      else
         $display("[FAIL] regression broken");
      $finish;
   end

   // watchdog
   initial begin
      #20_000_000;
      $display("[FAIL] regression broken");
      $finish;
   end

endmodule

/* filelist.f */
+incdir+design
design/mlfq_pkg.sv
design/mlfq_req_if.sv
design/mlfq_rsp_if.sv
design/mlfq_ctrl.sv
design/mlfq_datapath.sv
design/multilevel_feedback_queue_scheduler_core.sv
verif/tb_multilevel_feedback_queue_scheduler_core.sv
